// ===== rtl/ltsw_pkg.sv =====
package ltsw_pkg;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_SKIP,
      PH_ERRHEAD,
      PH_ERRCHAR,
      PH_STOP
   } phase_type;

   localparam logic [7:0] TYPE_CLASS_MASK = 8'h30;
   localparam logic [7:0] TYPE_CLASS_VAR  = 8'h20;
   localparam logic [7:0] TYPE_LOGINACK   = 8'hAD;
   localparam logic [7:0] TYPE_ERROR      = 8'hAA;
   localparam logic [7:0] TYPE_DONE       = 8'hFD;
   localparam logic [7:0] TYPE_DONEPROC   = 8'hFE;
   localparam logic [7:0] TYPE_DONEINPROC = 8'hFF;

   localparam logic [15:0] DONE_BODY_LEN = 16'd12;
   localparam logic [15:0] ERROR_MIN_LEN = 16'd8;
   localparam logic [2:0]  COUNT_LO_OFS  = 3'd6;
   localparam logic [2:0]  COUNT_HI_OFS  = 3'd7;
   localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
   localparam logic [6:0]  SUBST_CHAR    = 7'h3F;

   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       result_kind;
      logic [6:0] message_char;
      logic       message_last;
      logic       login_acknowledged;
      logic       stopped_on_unknown;
      logic       last_result;
   } result_type;

   // results of one request, first one in queue order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

endpackage

// ===== rtl/ltsw_req_if.sv =====
interface ltsw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_stream;

   modport source (output valid, data_byte, byte_present, end_of_stream, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_stream, output ready);
endinterface

// ===== rtl/ltsw_rsp_if.sv =====
interface ltsw_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [6:0] message_char;
   logic       message_last;
   logic       login_acknowledged;
   logic       stopped_on_unknown;
   logic       last_result;

   modport source (output valid, result_kind, message_char, message_last,
                   login_acknowledged, stopped_on_unknown, last_result, input ready);
   modport sink (input valid, result_kind, message_char, message_last,
                 login_acknowledged, stopped_on_unknown, last_result, output ready);
endinterface

// ===== rtl/ltsw_parser.sv =====
module ltsw_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         data_byte,
   input  logic               byte_present,
   input  logic               end_of_stream,
   output ltsw_pkg::step_type step
);
   import ltsw_pkg::*;

   phase_type   phase_ff, phase_in, phase_nx;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  current_type_ff, current_type_in;
   logic [7:0]  length_low_ff, length_low_in;
   logic [2:0]  body_offset_ff, body_offset_in;
   logic [15:0] chars_left_ff, chars_left_in;
   logic [7:0]  char_low_ff, char_low_in;
   logic        ack_seen_ff, ack_seen_in, ack_nx;

   logic        eat;
   logic [15:0] token_len;
   logic [15:0] bytes_dec;
   logic [15:0] msg_count;
   logic [15:0] max_chars;
   logic [15:0] clamped;
   logic [15:0] chars_dec;
   phase_type   after_body;
   logic        char_emit;
   logic [6:0]  char_value;

   assign eat        = take && byte_present;
   assign token_len  = {data_byte, length_low_ff};
   assign bytes_dec  = bytes_left_ff - 16'd1;
   assign msg_count  = {data_byte, char_low_ff};
   assign max_chars  = {1'b0, bytes_dec[15:1]};
   assign clamped    = (msg_count < max_chars) ? msg_count : max_chars;
   assign chars_dec  = chars_left_ff - 16'd1;
   // token body is consumed through the byte in hand
   assign after_body = (bytes_dec != 16'd0) ? PH_SKIP : PH_TYPE;

   // next phase
   always_comb begin
      phase_nx = phase_ff;
      if (eat) begin
         unique case (phase_ff)
            PH_TYPE: begin
               if ((data_byte & TYPE_CLASS_MASK) == TYPE_CLASS_VAR) begin
                  phase_nx = PH_LEN_LO;
               end else if (data_byte == TYPE_DONE || data_byte == TYPE_DONEPROC ||
                            data_byte == TYPE_DONEINPROC) begin
                  phase_nx = PH_SKIP;
               end else begin
                  phase_nx = PH_STOP;
               end
            end
            PH_LEN_LO: phase_nx = PH_LEN_HI;
            PH_LEN_HI: begin
               if (current_type_ff == TYPE_ERROR && token_len >= ERROR_MIN_LEN) begin
                  phase_nx = PH_ERRHEAD;
               end else begin
                  phase_nx = (token_len != 16'd0) ? PH_SKIP : PH_TYPE;
               end
            end
            PH_SKIP: begin
               if (bytes_dec == 16'd0) begin
                  phase_nx = PH_TYPE;
               end
            end
            PH_ERRHEAD: begin
               if (body_offset_ff == COUNT_HI_OFS) begin
                  phase_nx = (clamped != 16'd0) ? PH_ERRCHAR : after_body;
               end
            end
            PH_ERRCHAR: begin
               if (body_offset_ff[0] && chars_dec == 16'd0) begin
                  phase_nx = after_body;
               end
            end
            PH_STOP: phase_nx = PH_STOP;
            default: phase_nx = PH_TYPE;
         endcase
      end
      phase_in = (take && end_of_stream) ? PH_TYPE : phase_nx;
   end

   // datapath registers
   always_comb begin
      bytes_left_in   = bytes_left_ff;
      current_type_in = current_type_ff;
      length_low_in   = length_low_ff;
      body_offset_in  = body_offset_ff;
      chars_left_in   = chars_left_ff;
      char_low_in     = char_low_ff;
      ack_nx          = ack_seen_ff;
      if (eat) begin
         case (phase_ff)
            PH_TYPE: begin
               current_type_in = data_byte;
               if (data_byte == TYPE_DONE || data_byte == TYPE_DONEPROC ||
                   data_byte == TYPE_DONEINPROC) begin
                  if ((data_byte & TYPE_CLASS_MASK) != TYPE_CLASS_VAR) begin
                     bytes_left_in = DONE_BODY_LEN;
                  end
               end
            end
            PH_LEN_LO: length_low_in = data_byte;
            PH_LEN_HI: begin
               bytes_left_in  = token_len;
               body_offset_in = '0;
               if (current_type_ff == TYPE_LOGINACK) begin
                  ack_nx = 1'b1;
               end
            end
            PH_SKIP: bytes_left_in = bytes_dec;
            PH_ERRHEAD: begin
               bytes_left_in  = bytes_dec;
               // offset wraps to zero after the count: only its parity matters later
               body_offset_in = body_offset_ff + 3'd1;
               if (body_offset_ff == COUNT_LO_OFS) begin
                  char_low_in = data_byte;
               end
               if (body_offset_ff == COUNT_HI_OFS) begin
                  chars_left_in = clamped;
               end
            end
            PH_ERRCHAR: begin
               bytes_left_in  = bytes_dec;
               body_offset_in = body_offset_ff + 3'd1;
               if (!body_offset_ff[0]) begin
                  char_low_in = data_byte;
               end else begin
                  chars_left_in = chars_dec;
               end
            end
            default: ;
         endcase
      end
      ack_seen_in = ack_nx;
      if (take && end_of_stream) begin
         bytes_left_in   = '0;
         current_type_in = '0;
         length_low_in   = '0;
         body_offset_in  = '0;
         chars_left_in   = '0;
         char_low_in     = '0;
         ack_seen_in     = 1'b0;
      end
   end

   assign char_emit  = eat && phase_ff == PH_ERRCHAR && body_offset_ff[0];
   assign char_value = (data_byte == 8'd0 && char_low_ff < ASCII_LIMIT) ?
                       char_low_ff[6:0] : SUBST_CHAR;

   // results of the request in hand
   always_comb begin
      result_type chr;
      result_type vrd;
      chr.result_kind        = KIND_CHAR;
      chr.message_char       = char_value;
      chr.message_last       = (chars_dec == 16'd0);
      chr.login_acknowledged = 1'b0;
      chr.stopped_on_unknown = 1'b0;
      chr.last_result        = !end_of_stream;
      vrd.result_kind        = KIND_VERDICT;
      vrd.message_char       = '0;
      vrd.message_last       = 1'b0;
      vrd.login_acknowledged = ack_nx;
      vrd.stopped_on_unknown = (phase_nx == PH_STOP);
      vrd.last_result        = 1'b1;
      step.first  = char_emit ? chr : vrd;
      step.second = vrd;
      step.count  = {1'b0, char_emit} + {1'b0, take && end_of_stream};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TYPE;
         bytes_left_ff   <= '0;
         current_type_ff <= '0;
         length_low_ff   <= '0;
         body_offset_ff  <= '0;
         chars_left_ff   <= '0;
         char_low_ff     <= '0;
         ack_seen_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         current_type_ff <= current_type_in;
         length_low_ff   <= length_low_in;
         body_offset_ff  <= body_offset_in;
         chars_left_ff   <= chars_left_in;
         char_low_ff     <= char_low_in;
         ack_seen_ff     <= ack_seen_in;
      end
   end

   a_stop_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STOP && !(take && end_of_stream)) |=> phase_ff == PH_STOP)
      else $error("stopped parser resumed before end of stream");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (take && end_of_stream) |=> (phase_ff == PH_TYPE && !ack_seen_ff))
      else $error("state not cleared after end of stream");

   a_char_phase: assert property (@(posedge clock) disable iff (reset)
      char_emit |-> chars_left_ff != 16'd0)
      else $error("character emitted with empty message count");

endmodule

// ===== rtl/login_token_stream_walker.sv =====
// Walks a login-response token stream, one byte per request, and takes a new
// request in every cycle while the result queue has room for two results.
// Each byte is decoded in the same cycle it is taken; its results (at most an
// error character and the end-of-stream verdict) enter a four-entry queue and
// leave one per cycle, while the receiver is ready, on the response channel, so
// a request that ends the stream after a character yields two responses. Results
// are registered in the queue before they are offered.
module login_token_stream_walker (
   input logic       clock,
   input logic       reset,
   ltsw_req_if.sink  req,
   ltsw_rsp_if.source rsp
);
   import ltsw_pkg::*;

   result_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     take;
   logic                     pop;
   step_type                 step;
   logic [QUEUE_PTR_W-1:0]   wr_next;
   result_type               head;

   assign req.ready = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign take      = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;

   ltsw_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .data_byte     (req.data_byte),
      .byte_present  (req.byte_present),
      .end_of_stream (req.end_of_stream),
      .step          (step)
   );

   assign wr_next   = wr_ptr_ff + QUEUE_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(step.count);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
   assign count_in  = count_ff + QUEUE_CNT_W'(step.count) - QUEUE_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (step.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= step.first;
      end
      if (step.count == 2'd2) begin
         queue_ff[wr_next] <= step.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head                   = queue_ff[rd_ptr_ff];
   assign rsp.valid              = (count_ff != '0);
   assign rsp.result_kind        = head.result_kind;
   assign rsp.message_char       = head.message_char;
   assign rsp.message_last       = head.message_last;
   assign rsp.login_acknowledged = head.login_acknowledged;
   assign rsp.stopped_on_unknown = head.stopped_on_unknown;
   assign rsp.last_result        = head.last_result;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_room_on_take: assert property (@(posedge clock) disable iff (reset)
      take |-> count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2))
      else $error("request taken without room for two results");

   a_verdict_queued: assert property (@(posedge clock) disable iff (reset)
      (take && req.end_of_stream) |=> rsp.valid)
      else $error("end of stream left no verdict in the queue");

   a_only_take_writes: assert property (@(posedge clock) disable iff (reset)
      !take |-> step.count == 2'd0)
      else $error("results produced without a request");

endmodule

// ===== sim/login_token_stream_walker_tb.sv =====
`timescale 1ns / 1ps

module login_token_stream_walker_tb;
   import ltsw_pkg::*;

   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int ITEM_TARGET    = 850;
   localparam int TAIL_ITEMS     = 100;
   localparam int PAUSE_AT       = 500;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 80;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PRINT_LIMIT    = 200;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_stream;
   } token_req_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid_q   = 1'b0;
   logic [7:0] req_byte_q    = 8'h00;
   logic       req_present_q = 1'b0;
   logic       req_eos_q     = 1'b0;
   logic       rsp_ready_q   = 1'b0;

   ltsw_req_if req_bus();
   ltsw_rsp_if rsp_bus();

   assign req_bus.valid         = req_valid_q;
   assign req_bus.data_byte     = req_byte_q;
   assign req_bus.byte_present  = req_present_q;
   assign req_bus.end_of_stream = req_eos_q;
   assign rsp_bus.ready         = rsp_ready_q;

   login_token_stream_walker i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   token_req_type req_q[$];
   logic [7:0]    stream_bytes[$];
   result_type    due_results[$];

   int            err_cnt       = 0;
   int            accepted_reqs = 0;
   int            total_reqs    = 0;
   int            send_idle     = 0;
   bit            pause_done    = 1'b0;
   bit            tail_mode     = 1'b0;
   token_req_type cur_req;
   int            rsp_idle      = 0;
   int            rsp_hold_left = 0;
   int            reqs_seen     = 0;
   bit            hold_done     = 1'b0;
   int            quiet_cycles  = 0;

   // walker state mirror
   phase_type   walk_phase = PH_TYPE;
   logic [15:0] body_left  = 16'd0;
   logic [7:0]  tok_kind   = 8'h00;
   logic [7:0]  len_lo     = 8'h00;
   logic [15:0] err_ofs    = 16'd0;
   logic [15:0] chars_left = 16'd0;
   logic [7:0]  lo_byte    = 8'h00;
   logic        ack_flag   = 1'b0;

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report(input string msg);
      if (err_cnt < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, msg);
      err_cnt++;
   endtask

   task automatic check_field(input string name, input logic [6:0] got,
                              input logic [6:0] want);
      if (got !== want)
         report($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic finish_body();
      walk_phase = (body_left != 16'd0) ? PH_SKIP : PH_TYPE;
   endtask

   task automatic walk_request_byte(input token_req_type it);
      logic [7:0]  b;
      logic [15:0] len;
      logic [15:0] cnt;
      logic [15:0] maxc;
      logic        emit;
      result_type  r;
      b    = it.data_byte;
      emit = 1'b0;
      r    = '0;
      if (it.byte_present) begin
         case (walk_phase)
            PH_TYPE: begin
               tok_kind = b;
               if ((b & TYPE_CLASS_MASK) == TYPE_CLASS_VAR) begin
                  walk_phase = PH_LEN_LO;
               end else if (b == TYPE_DONE || b == TYPE_DONEPROC || b == TYPE_DONEINPROC) begin
                  body_left  = DONE_BODY_LEN;
                  walk_phase = PH_SKIP;
               end else begin
                  walk_phase = PH_STOP;
               end
            end
            PH_LEN_LO: begin
               len_lo     = b;
               walk_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               len       = {b, len_lo};
               body_left = len;
               if (tok_kind == TYPE_LOGINACK)
                  ack_flag = 1'b1;
               if (tok_kind == TYPE_ERROR && len >= ERROR_MIN_LEN) begin
                  err_ofs    = 16'd0;
                  walk_phase = PH_ERRHEAD;
               end else begin
                  finish_body();
               end
            end
            PH_SKIP: begin
               body_left = body_left - 16'd1;
               if (body_left == 16'd0)
                  walk_phase = PH_TYPE;
            end
            PH_ERRHEAD: begin
               body_left = body_left - 16'd1;
               if (err_ofs == {13'd0, COUNT_LO_OFS})
                  lo_byte = b;
               if (err_ofs == {13'd0, COUNT_HI_OFS}) begin
                  cnt        = {b, lo_byte};
                  maxc       = body_left >> 1;
                  chars_left = (cnt < maxc) ? cnt : maxc;
                  err_ofs    = ERROR_MIN_LEN;
                  if (chars_left != 16'd0)
                     walk_phase = PH_ERRCHAR;
                  else
                     finish_body();
               end else begin
                  err_ofs = err_ofs + 16'd1;
               end
            end
            PH_ERRCHAR: begin
               body_left = body_left - 16'd1;
               if (!err_ofs[0]) begin
                  lo_byte = b;
                  err_ofs = err_ofs + 16'd1;
               end else begin
                  err_ofs = err_ofs + 16'd1;
                  emit    = 1'b1;
                  // utf-16 code units above 7 bits become a substitute
                  r.message_char = (b == 8'h00 && lo_byte < ASCII_LIMIT) ? lo_byte[6:0]
                                                                         : SUBST_CHAR;
                  chars_left     = chars_left - 16'd1;
                  r.message_last = (chars_left == 16'd0);
                  if (chars_left == 16'd0)
                     finish_body();
               end
            end
            default: begin
            end
         endcase
      end
      if (emit) begin
         r.result_kind = KIND_CHAR;
         r.last_result = !it.end_of_stream;
         due_results.push_back(r);
      end
      if (it.end_of_stream) begin
         r = '0;
         r.result_kind        = KIND_VERDICT;
         r.login_acknowledged = ack_flag;
         r.stopped_on_unknown = (walk_phase == PH_STOP);
         r.last_result        = 1'b1;
         due_results.push_back(r);
         walk_phase = PH_TYPE;
         body_left  = 16'd0;
         tok_kind   = 8'h00;
         len_lo     = 8'h00;
         err_ofs    = 16'd0;
         chars_left = 16'd0;
         lo_byte    = 8'h00;
         ack_flag   = 1'b0;
      end
   endtask

   task automatic put_req(input logic [7:0] b, input logic present, input logic eos);
      token_req_type t;
      t.data_byte     = b;
      t.byte_present  = present;
      t.end_of_stream = eos;
      req_q.push_back(t);
   endtask

   task automatic add_var_token(input logic [7:0] kind, input int len);
      logic [15:0] l;
      l = 16'(len);
      stream_bytes.push_back(kind);
      stream_bytes.push_back(l[7:0]);
      stream_bytes.push_back(l[15:8]);
      repeat (len) stream_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_error_token();
      int          nch;
      int          len;
      int          i;
      logic [15:0] cnt;
      logic [15:0] l;
      nch = $urandom_range(0, 5);
      if ($urandom_range(0, 7) == 0)
         len = $urandom_range(0, 7);
      else
         len = 8 + 2 * nch + $urandom_range(0, 3);
      case ($urandom_range(0, 5))
         0: cnt = 16'd0;
         1: cnt = 16'(nch + $urandom_range(1, 300));
         2: cnt = 16'($urandom_range(0, 65535));
         default: cnt = 16'(nch);
      endcase
      l = 16'(len);
      stream_bytes.push_back(TYPE_ERROR);
      stream_bytes.push_back(l[7:0]);
      stream_bytes.push_back(l[15:8]);
      for (i = 0; i < len; i++) begin
         if (i == 6)
            stream_bytes.push_back(cnt[7:0]);
         else if (i == 7)
            stream_bytes.push_back(cnt[15:8]);
         else if (i < 6)
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         else if ((i - 8) % 2 == 0)
            stream_bytes.push_back(8'(($urandom_range(0, 9) < 7) ? $urandom_range(32, 126)
                                                                 : $urandom_range(0, 255)));
         else
            stream_bytes.push_back(8'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                                  : 0));
      end
   endtask

   task automatic add_done_token();
      case ($urandom_range(0, 2))
         0: stream_bytes.push_back(TYPE_DONE);
         1: stream_bytes.push_back(TYPE_DONEPROC);
         default: stream_bytes.push_back(TYPE_DONEINPROC);
      endcase
      repeat (DONE_BODY_LEN) stream_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_random_token();
      int         pick;
      int         len;
      logic [7:0] kind;
      pick = $urandom_range(0, 9);
      len  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0)
         len = $urandom_range(13, 80);
      if (pick <= 3) begin
         add_error_token();
      end else if (pick <= 6) begin
         kind = (pick == 6) ? TYPE_LOGINACK
                            : ((8'($urandom_range(0, 255)) & 8'hCF) | TYPE_CLASS_VAR);
         add_var_token(kind, len);
      end else begin
         add_done_token();
      end
   endtask

   task automatic add_unknown_type();
      logic [7:0] b;
      b = TYPE_CLASS_VAR;
      while ((b & TYPE_CLASS_MASK) == TYPE_CLASS_VAR || b == TYPE_DONE ||
             b == TYPE_DONEPROC || b == TYPE_DONEINPROC)
         b = 8'($urandom_range(0, 255));
      stream_bytes.push_back(b);
   endtask

   // turn the built byte stream into requests, with stray markers mixed in
   task automatic flush_stream(input bit eos_on_last);
      int i;
      for (i = 0; i < stream_bytes.size(); i++) begin
         if ($urandom_range(0, 15) == 0)
            put_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         put_req(stream_bytes[i], 1'b1, eos_on_last && (i == stream_bytes.size() - 1));
      end
      if (!eos_on_last || stream_bytes.size() == 0)
         put_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      stream_bytes.delete();
   endtask

   always @(posedge clock) begin : drive_proc
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_valid_q <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            walk_request_byte(cur_req);
            accepted_reqs++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_idle > 0) begin
               send_idle--;
            end else if (req_q.size() == 0) begin
               offer = 1'b0;
            end else if (accepted_reqs == PAUSE_AT && !pause_done && due_results.size() != 0) begin
               // hold the sender until the block has drained
               offer = 1'b0;
            end else if (req_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
               send_idle = $urandom_range(0, 6);
            end else begin
               cur_req = req_q.pop_front();
               offer   = 1'b1;
               if (accepted_reqs == PAUSE_AT)
                  pause_done = 1'b1;
            end
            req_valid_q <= offer;
            if (offer) begin
               req_byte_q    <= cur_req.data_byte;
               req_present_q <= cur_req.byte_present;
               req_eos_q     <= cur_req.end_of_stream;
            end
         end
         tail_mode <= (req_q.size() <= TAIL_ITEMS);
      end
   end

   always @(posedge clock) begin : check_proc
      result_type want;
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_results.size() == 0) begin
               report("response with no request waiting for it");
            end else begin
               want = due_results.pop_front();
               check_field("result_kind", 7'(rsp_bus.result_kind), 7'(want.result_kind));
               check_field("message_char", rsp_bus.message_char, want.message_char);
               check_field("message_last", 7'(rsp_bus.message_last),
                           7'(want.message_last));
               check_field("login_acknowledged", 7'(rsp_bus.login_acknowledged),
                           7'(want.login_acknowledged));
               check_field("stopped_on_unknown", 7'(rsp_bus.stopped_on_unknown),
                           7'(want.stopped_on_unknown));
               check_field("last_result", 7'(rsp_bus.last_result), 7'(want.last_result));
            end
         end
         if (rsp_hold_left != 0) begin
            rsp_ready_q <= 1'b0;
         end else if (rsp_idle > 0) begin
            rsp_idle--;
            rsp_ready_q <= 1'b0;
         end else if (!tail_mode && $urandom_range(0, 7) == 0) begin
            rsp_idle = $urandom_range(0, 6);
            rsp_ready_q <= 1'b0;
         end else begin
            rsp_ready_q <= 1'b1;
         end
      end
   end

   // one long receiver stall so the result queue fills and backs up the input
   always @(posedge clock) begin : hold_proc
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            reqs_seen <= reqs_seen + 1;
         if (rsp_hold_left != 0) begin
            rsp_hold_left <= rsp_hold_left - 1;
         end else if (!hold_done && reqs_seen >= HOLD_AT) begin
            rsp_hold_left <= HOLD_CYCLES;
            hold_done     <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog_proc
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : stim_proc
      int sel;
      int ntok;
      int pre;
      int keep;

      // bare marker mid-stream does nothing
      put_req(8'h5A, 1'b0, 1'b0);
      // loginack whose length is cut short does not count
      put_req(TYPE_LOGINACK, 1'b1, 1'b0);
      put_req(8'h05, 1'b1, 1'b1);
      // unknown type, then a bare end marker
      put_req(8'h7F, 1'b1, 1'b0);
      put_req(8'hFF, 1'b0, 1'b1);
      // full loginack, then an error token of maximal length and count that
      // gets truncated halfway through a character
      add_var_token(TYPE_LOGINACK, 0);
      stream_bytes.push_back(TYPE_ERROR);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'h7F);
      stream_bytes.push_back(8'h01);
      stream_bytes.push_back(8'hFE);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h41);
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'h41);
      stream_bytes.push_back(8'h01);
      stream_bytes.push_back(8'h7A);
      flush_stream(1'b1);

      while (req_q.size() < ITEM_TARGET) begin
         sel  = $urandom_range(0, 9);
         ntok = $urandom_range(1, 4);
         if (sel <= 6) begin
            repeat (ntok) add_random_token();
            flush_stream(1'($urandom_range(0, 1)));
         end else if (sel == 7) begin
            // stream ends inside its last token
            repeat (ntok - 1) add_random_token();
            pre = stream_bytes.size();
            add_random_token();
            if (stream_bytes.size() - pre > 1) begin
               keep = pre + $urandom_range(1, stream_bytes.size() - pre - 1);
               while (stream_bytes.size() > keep)
                  void'(stream_bytes.pop_back());
            end
            flush_stream(1'($urandom_range(0, 1)));
         end else if (sel == 8) begin
            repeat (ntok - 1) add_random_token();
            add_unknown_type();
            repeat ($urandom_range(0, 5)) stream_bytes.push_back(8'($urandom_range(0, 255)));
            flush_stream(1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 8)) stream_bytes.push_back(8'($urandom_range(0, 255)));
            flush_stream(1'($urandom_range(0, 1)));
         end
      end
      total_reqs = req_q.size();

      while (accepted_reqs < total_reqs) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
